### design/tbs_pkg.sv
// Package for the tile buffer scheduler.
// Holds event codes, tile phases, result actions and the result record.
// No dependencies.
package tbs_pkg;

  localparam int unsigned ModeW = 2;
  localparam int unsigned RowW  = 9;
  localparam int unsigned ActW  = 3;

  typedef enum logic [ModeW-1:0] {
    MODE_ALLOC      = 2'd0,
    MODE_SEND       = 2'd1,
    MODE_SEND_DONE  = 2'd2,
    MODE_CLEAR_DONE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    PH_CLEARED    = 3'd0,
    PH_DRAWING    = 3'd1,
    PH_SEND_WAIT  = 3'd2,
    PH_SENDING    = 3'd3,
    PH_CLEAR_WAIT = 3'd4,
    PH_CLEARING   = 3'd5
  } phase_e;

  typedef enum logic [ActW-1:0] {
    ACT_NONE    = 3'd0,
    ACT_ALLOC   = 3'd1,
    ACT_REFUSED = 3'd2,
    ACT_SEND    = 3'd3,
    ACT_CLEAR   = 3'd4
  } action_e;

  typedef struct packed {
    action_e           action;
    logic              which_tile;
    logic [RowW-1:0]   window_start;
    logic [RowW-1:0]   window_rows;
    logic              last;
  } res_t;

endpackage

### design/tbs_in_if.sv
// Event channel of the tile buffer scheduler.
// Depends on tbs_pkg for field widths.
interface tbs_in_if import tbs_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ModeW-1:0] mode;
  logic            tile;
  logic [RowW-1:0] row_start;
  logic [RowW-1:0] row_count;

  modport source (output valid, mode, tile, row_start, row_count, input ready);
  modport sink   (input valid, mode, tile, row_start, row_count, output ready);
endinterface

### design/tbs_out_if.sv
// Result channel of the tile buffer scheduler.
// Depends on tbs_pkg for field widths.
interface tbs_out_if import tbs_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ActW-1:0] action;
  logic            which_tile;
  logic [RowW-1:0] window_start;
  logic [RowW-1:0] window_rows;
  logic            last;

  modport source (output valid, action, which_tile, window_start, window_rows, last,
                  input ready);
  modport sink   (input valid, action, which_tile, window_start, window_rows, last,
                  output ready);
endinterface

### design/tbs_seq.sv
// Tile walker: holds tile phases, row windows and engine busy flags, and
// steps through the tiles for each event transaction, one per cycle while
// the result queue has room. Depends on tbs_pkg and tbs_in_if.
module tbs_seq import tbs_pkg::*; #(
  parameter int unsigned NUM_TILES = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  tbs_in_if.sink   in_i,
  output logic     push_valid_o,
  output res_t     push_data_o,
  input  logic     push_ready_i
);

  localparam int unsigned IdxW = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_e;

  state_e          state_q;
  mode_e           mode_q;
  logic [IdxW-1:0] idx_q;
  logic [RowW-1:0] rs_q, rc_q;
  logic            found_q;
  logic [1:0]      n_q;
  logic            pend_valid_q;
  res_t            pend_q;
  phase_e          phase_q [NUM_TILES];
  logic [RowW-1:0] first_row_q [NUM_TILES];
  logic [RowW-1:0] rows_q [NUM_TILES];
  logic            send_busy_q, clear_busy_q;

  phase_e          ph, ph_d;
  logic            send_busy_d, clear_busy_d;
  logic            emit, emit_ok, wr_rows, set_found, stall, last_step;
  res_t            emit_res, finish_res;
  logic            accept;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    ph           = phase_q[idx_q];
    ph_d         = ph;
    send_busy_d  = send_busy_q;
    clear_busy_d = clear_busy_q;
    emit         = 1'b0;
    emit_res     = '0;
    wr_rows      = 1'b0;
    set_found    = 1'b0;
    emit_res.which_tile = idx_q[0];
    unique case (mode_q)
      MODE_ALLOC: begin
        if (!found_q && ph == PH_CLEARED) begin
          ph_d            = PH_DRAWING;
          wr_rows         = 1'b1;
          set_found       = 1'b1;
          emit            = 1'b1;
          emit_res.action = ACT_ALLOC;
        end
      end
      MODE_SEND: begin
        if (ph == PH_DRAWING) begin
          if (send_busy_q) begin
            ph_d = PH_SEND_WAIT;
          end else begin
            ph_d                  = PH_SENDING;
            send_busy_d           = 1'b1;
            emit                  = 1'b1;
            emit_res.action       = ACT_SEND;
            emit_res.window_start = first_row_q[idx_q];
            emit_res.window_rows  = rows_q[idx_q];
          end
        end
      end
      MODE_SEND_DONE: begin
        if (ph == PH_SENDING) begin
          if (clear_busy_q) begin
            ph_d = PH_CLEAR_WAIT;
          end else begin
            ph_d            = PH_CLEARING;
            clear_busy_d    = 1'b1;
            emit            = 1'b1;
            emit_res.action = ACT_CLEAR;
          end
        end else if (ph == PH_SEND_WAIT && !send_busy_q) begin
          ph_d                  = PH_SENDING;
          send_busy_d           = 1'b1;
          emit                  = 1'b1;
          emit_res.action       = ACT_SEND;
          emit_res.window_start = first_row_q[idx_q];
          emit_res.window_rows  = rows_q[idx_q];
        end
      end
      MODE_CLEAR_DONE: begin
        if (ph == PH_CLEARING) begin
          ph_d = PH_CLEARED;
        end else if (ph == PH_CLEAR_WAIT && !clear_busy_q) begin
          ph_d            = PH_CLEARING;
          clear_busy_d    = 1'b1;
          emit            = 1'b1;
          emit_res.action = ACT_CLEAR;
        end
      end
    endcase
    emit_ok   = emit && (n_q < 2'd2);
    stall     = emit_ok && pend_valid_q && !push_ready_i;
    last_step = (mode_q == MODE_SEND) || set_found || (idx_q == IdxW'(NUM_TILES - 1));

    finish_res      = '0;
    finish_res.last = 1'b1;
    if (pend_valid_q) begin
      finish_res      = pend_q;
      finish_res.last = 1'b1;
    end else if (mode_q == MODE_ALLOC) begin
      finish_res.action = ACT_REFUSED;
    end else begin
      finish_res.action = ACT_NONE;
    end

    push_valid_o = 1'b0;
    push_data_o  = pend_q;
    if (state_q == S_WALK) begin
      push_valid_o = emit_ok && pend_valid_q;
    end else if (state_q == S_FINISH) begin
      push_valid_o = 1'b1;
      push_data_o  = finish_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mode_q       <= MODE_ALLOC;
      idx_q        <= '0;
      found_q      <= 1'b0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      send_busy_q  <= 1'b0;
      clear_busy_q <= 1'b0;
      for (int i = 0; i < NUM_TILES; i++) begin
        phase_q[i] <= PH_CLEARED;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            mode_q       <= mode_e'(in_i.mode);
            idx_q        <= (mode_e'(in_i.mode) == MODE_SEND) ? IdxW'(in_i.tile) : '0;
            found_q      <= 1'b0;
            n_q          <= '0;
            pend_valid_q <= 1'b0;
            if (mode_e'(in_i.mode) == MODE_SEND_DONE) begin
              send_busy_q <= 1'b0;
            end
            if (mode_e'(in_i.mode) == MODE_CLEAR_DONE) begin
              clear_busy_q <= 1'b0;
            end
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          if (!stall) begin
            phase_q[idx_q] <= ph_d;
            send_busy_q    <= send_busy_d;
            clear_busy_q   <= clear_busy_d;
            if (set_found) begin
              found_q <= 1'b1;
            end
            if (emit_ok) begin
              pend_q       <= emit_res;
              pend_valid_q <= 1'b1;
              n_q          <= n_q + 2'd1;
            end
            if (last_step) begin
              state_q <= S_FINISH;
            end else begin
              idx_q <= idx_q + IdxW'(1);
            end
          end
        end
        S_FINISH: begin
          if (push_ready_i) begin
            pend_valid_q <= 1'b0;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      if (accept) begin
        rs_q <= in_i.row_start;
        rc_q <= in_i.row_count;
      end
    end else if (state_q == S_WALK && !stall && wr_rows) begin
      first_row_q[idx_q] <= rs_q;
      rows_q[idx_q]      <= rc_q;
    end
  end

endmodule

### design/tbs_out_buf.sv
// Two-entry result queue in front of the result channel.
// Depends on tbs_pkg and tbs_out_if.
module tbs_out_buf import tbs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  input  res_t      push_data_i,
  output logic      push_ready_o,
  tbs_out_if.source out_o
);

  res_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  res_t       head;

  assign push_ready_o = (cnt_q != 2'd2);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = out_o.valid && out_o.ready;
  assign head         = mem_q[rd_q];

  assign out_o.valid        = (cnt_q != 2'd0);
  assign out_o.action       = head.action;
  assign out_o.which_tile   = head.which_tile;
  assign out_o.window_start = head.window_start;
  assign out_o.window_rows  = head.window_rows;
  assign out_o.last         = head.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

### design/tile_buffer_scheduler.sv
// Tile buffer scheduler, top level.
// Depends on tbs_pkg, tbs_in_if, tbs_out_if, tbs_seq and tbs_out_buf.
//
// Use: events (allocate, send, send done, clear done) arrive on in_i as
// valid/ready transactions; each event yields one or two results on out_o,
// the final one marked by last. The input is ready only while no event is
// being worked on. A send event visits only its named tile (accept, one
// tile step, finish); the other events walk the tiles, one tile per cycle
// while the queue has room (an allocate stops at the first cleared tile).
// Results pass through a two-entry queue, so each result is registered
// there before it appears on out_o. When the receiver stalls, the queue
// fills and the walker holds until there is room; nothing is lost.
// Reset marks all tiles cleared and both engines idle; the row windows are
// only meaningful once a tile has been allocated.
module tile_buffer_scheduler import tbs_pkg::*; #(
  parameter int unsigned NUM_TILES = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tbs_in_if.sink    in_i,
  tbs_out_if.source out_o
);

  logic push_valid, push_ready;
  res_t push_data;

  tbs_seq #(
    .NUM_TILES (NUM_TILES)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  tbs_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .out_o        (out_o)
  );

endmodule
